// File: src/lmlt_pkg.sv
// Shared types and timing constants for the LCD mode and line timing block.
`timescale 1ns / 1ps
package lmlt_pkg;

    // Mode codes as seen on the lcd_mode output.
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    localparam int unsigned ACCUM_W = 10;
    localparam int unsigned TICKS_W = 6;
    localparam int unsigned LINE_W  = 8;

    // Mode lengths in ticks.
    localparam logic [ACCUM_W-1:0] LEN_OAM      = 10'd80;
    localparam logic [ACCUM_W-1:0] LEN_TRANSFER = 10'd172;
    localparam logic [ACCUM_W-1:0] LEN_HBLANK   = 10'd204;
    localparam logic [ACCUM_W-1:0] LEN_VLINE    = 10'd456;

    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

    // Timing state, one-hot.
    typedef enum logic [3:0] {
        ST_HBLANK   = 4'b0001,
        ST_VBLANK   = 4'b0010,
        ST_OAM      = 4'b0100,
        ST_TRANSFER = 4'b1000
    } lcd_state_t;

endpackage

// File: src/lcd_mode_line_timing_top.sv
// Top level of the LCD mode and scan-line timing block.
`timescale 1ns / 1ps
// Each input item carries the number of ticks that have elapsed since the previous item.
// The block adds them to a mode accumulator and steps the four-mode LCD timing
// machine (OAM search 80 ticks, pixel transfer 172, HBLANK 204, VBLANK 456 per line),
// producing exactly one result item per input item with the mode and line after the
// step plus three pulses: vblank_irq (VBLANK entered while enabled), line_render
// (pixel transfer ended) and frame_start (line wrapped to zero). At most one mode
// change happens per item; leftover ticks carry into the next mode. Lines 0 to 143
// are visible and lines 144 to 153 are VBLANK. The block takes one item per cycle
// while out_stall is low: an item passes an input register and then lands in the
// result register. The sustained rate is set by the combinational add, compare
// and subtract loop on the timing state. While a result waits under out_stall,
// one more item is still accepted into the input register. The interrupt enable
// is written through the cfg port, which is always ready; it should be written
// only while no item is in flight.
module lcd_mode_line_timing_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input item channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lmlt_pkg::TICKS_W-1:0]  elapsed_ticks,
    // Result item channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    lcd_mode,
    output logic [lmlt_pkg::LINE_W-1:0]   line_number,
    output logic                          vblank_irq,
    output logic                          line_render,
    output logic                          frame_start,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          vblank_irq_enable
);
    import lmlt_pkg::*;

    // Input register stage.
    logic                s1_valid_reg, s1_valid_next;
    logic [TICKS_W-1:0]  ticks_reg;

    // Timing state.
    lcd_state_t          state_reg, state_next;
    logic [ACCUM_W-1:0]  accum_reg, accum_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic                irq_en_reg;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          mode_out_reg;
    logic [LINE_W-1:0]   line_out_reg;
    logic                irq_out_reg, render_out_reg, frame_out_reg;

    logic                in_take, out_free, s1_move;
    logic [ACCUM_W-1:0]  sum;
    logic [LINE_W-1:0]   line_inc;
    logic                irq_c, render_c, frame_c;
    logic [1:0]          mode_c;

    // The result register can take a new item when it is empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    assign sum      = accum_reg + {{(ACCUM_W-TICKS_W){1'b0}}, ticks_reg};
    assign line_inc = line_reg + 8'd1;

    // One step of the timing machine for the item in the input register.
    always_comb
    begin
        state_next = state_reg;
        accum_next = sum;
        line_next  = line_reg;
        irq_c      = 1'b0;
        render_c   = 1'b0;
        frame_c    = 1'b0;
        case (state_reg)
            ST_HBLANK:
            begin
                if (sum >= LEN_HBLANK)
                begin
                    line_next  = line_inc;
                    accum_next = sum - LEN_HBLANK;
                    if (line_inc == FIRST_VBLANK_LINE)
                    begin
                        irq_c      = irq_en_reg;
                        state_next = ST_VBLANK;
                    end
                    else
                    begin
                        state_next = ST_OAM;
                    end
                end
            end
            ST_VBLANK:
            begin
                if (sum >= LEN_VLINE)
                begin
                    accum_next = sum - LEN_VLINE;
                    if (line_inc > LAST_LINE)
                    begin
                        line_next  = '0;
                        state_next = ST_OAM;
                        frame_c    = 1'b1;
                    end
                    else
                    begin
                        line_next = line_inc;
                    end
                end
            end
            ST_OAM:
            begin
                if (sum >= LEN_OAM)
                begin
                    accum_next = sum - LEN_OAM;
                    state_next = ST_TRANSFER;
                end
            end
            ST_TRANSFER:
            begin
                if (sum >= LEN_TRANSFER)
                begin
                    accum_next = sum - LEN_TRANSFER;
                    state_next = ST_HBLANK;
                    render_c   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_OAM;
                accum_next = accum_reg;
            end
        endcase
    end

    // Map the one-hot state to the external mode code.
    always_comb
    begin
        case (state_next)
            ST_HBLANK:   mode_c = MODE_HBLANK;
            ST_VBLANK:   mode_c = MODE_VBLANK;
            ST_OAM:      mode_c = MODE_OAM;
            ST_TRANSFER: mode_c = MODE_TRANSFER;
            default:     mode_c = MODE_OAM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_OAM;
            accum_reg     <= '0;
            line_reg      <= '0;
            irq_en_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                state_reg <= state_next;
                accum_reg <= accum_next;
                line_reg  <= line_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                irq_en_reg <= vblank_irq_enable;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ticks_reg <= elapsed_ticks;
        end
        if (s1_move)
        begin
            mode_out_reg   <= mode_c;
            line_out_reg   <= line_next;
            irq_out_reg    <= irq_c;
            render_out_reg <= render_c;
            frame_out_reg  <= frame_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lcd_mode    = mode_out_reg;
    assign line_number = line_out_reg;
    assign vblank_irq  = irq_out_reg;
    assign line_render = render_out_reg;
    assign frame_start = frame_out_reg;

endmodule

// File: src/lmlt_checker.sv
// Port-level assertions for the LCD mode and line timing block, with its bind.
`timescale 1ns / 1ps
module lmlt_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    lcd_mode,
    input logic [lmlt_pkg::LINE_W-1:0]   line_number,
    input logic                          vblank_irq,
    input logic                          line_render,
    input logic                          frame_start
);
    import lmlt_pkg::*;

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lcd_mode) && $stable(line_number))
        else $error("stalled result item changed");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_number <= LAST_LINE)
        else $error("line number beyond last line");

    a_irq_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_irq |-> lcd_mode == MODE_VBLANK && line_number == FIRST_VBLANK_LINE)
        else $error("vblank interrupt outside vblank entry");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start |-> lcd_mode == MODE_OAM && line_number == '0)
        else $error("frame start without wrap to line zero");

    a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_render |-> lcd_mode == MODE_HBLANK
            && line_number < FIRST_VBLANK_LINE)
        else $error("line render outside visible hblank");

endmodule

bind lcd_mode_line_timing_top lmlt_checker u_lmlt_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the LCD mode and scan-line timing block.
`timescale 1ns / 1ps

import lmlt_pkg::*;

// One result item as the block reports it.
typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
    logic              irq;
    logic              render;
    logic              frame;
} lcd_step_t;

// Tracks the timing machine in step with the block and holds the results that
// are still owed, oldest first.
class lcd_timing_tracker;
    logic [1:0]         mode;
    logic [ACCUM_W-1:0] accum;
    logic [LINE_W-1:0]  line;
    logic               irq_enable;
    lcd_step_t          owed_steps[$];
    int                 mismatches;
    int                 items_taken;
    int                 results_seen;
    int                 vblank_entries;
    int                 irq_count;
    int                 render_count;
    int                 frame_count;

    function new();
        mode           = MODE_OAM;
        accum          = '0;
        line           = '0;
        irq_enable     = 1'b0;
        mismatches     = 0;
        items_taken    = 0;
        results_seen   = 0;
        vblank_entries = 0;
        irq_count      = 0;
        render_count   = 0;
        frame_count    = 0;
    endfunction

    function void set_irq_enable(logic en);
        irq_enable = en;
    endfunction

    function int pending();
        return owed_steps.size();
    endfunction

    // Advance the timing machine by one tick count and queue the result it owes.
    function void note_ticks(logic [TICKS_W-1:0] ticks);
        lcd_step_t step;
        step  = '0;
        accum = accum + ACCUM_W'(ticks);
        case (mode)
            MODE_HBLANK:
            begin
                if (accum >= LEN_HBLANK)
                begin
                    line = line + 1'b1;
                    if (line == FIRST_VBLANK_LINE)
                    begin
                        step.irq = irq_enable;
                        mode     = MODE_VBLANK;
                        vblank_entries++;
                    end
                    else
                    begin
                        mode = MODE_OAM;
                    end
                    accum = accum - LEN_HBLANK;
                end
            end
            MODE_VBLANK:
            begin
                if (accum >= LEN_VLINE)
                begin
                    line = line + 1'b1;
                    if (line > LAST_LINE)
                    begin
                        line       = '0;
                        mode       = MODE_OAM;
                        step.frame = 1'b1;
                    end
                    accum = accum - LEN_VLINE;
                end
            end
            MODE_OAM:
            begin
                if (accum >= LEN_OAM)
                begin
                    accum = accum - LEN_OAM;
                    mode  = MODE_TRANSFER;
                end
            end
            default:
            begin
                if (accum >= LEN_TRANSFER)
                begin
                    mode        = MODE_HBLANK;
                    step.render = 1'b1;
                    accum       = accum - LEN_TRANSFER;
                end
            end
        endcase
        step.mode = mode;
        step.line = line;
        items_taken++;
        irq_count    += step.irq;
        render_count += step.render;
        frame_count  += step.frame;
        owed_steps.push_back(step);
    endfunction

    // Prints are capped so a badly broken block cannot flood the log.
    task report(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     results_seen, what, got, want);
        end
    endtask

    task check_result(lcd_step_t got);
        lcd_step_t want;
        if (owed_steps.size() == 0)
        begin
            report("result with no item pending, lcd_mode", got.mode, -1);
            return;
        end
        want = owed_steps.pop_front();
        results_seen++;
        if (got.mode != want.mode)
            report("lcd_mode", got.mode, want.mode);
        if (got.line != want.line)
            report("line_number", got.line, want.line);
        if (got.irq != want.irq)
            report("vblank_irq", got.irq, want.irq);
        if (got.render != want.render)
            report("line_render", got.render, want.render);
        if (got.frame != want.frame)
            report("frame_start", got.frame, want.frame);
    endtask
endclass

module testbench;

    // The block moves an item from its input register to its result register, so
    // DRAIN_CYCLES covers anything still in flight.
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any accepted item, result or register write before the run
    // is declared hung. The longest legal quiet stretch is the receiver hold-off.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 60;
    // Random items per phase; with the directed opening this makes about 650.
    localparam int PHASE_ITEMS  = 210;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [TICKS_W-1:0] elapsed_ticks;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         lcd_mode;
    logic [LINE_W-1:0]  line_number;
    logic               vblank_irq;
    logic               line_render;
    logic               frame_start;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               vblank_irq_enable;

    // Idle rates in percent for the two sides; the sender's is only used by the
    // main process, the receiver's is handed over with nonblocking writes.
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    logic               long_hold_req;
    logic               long_hold_done;
    lcd_step_t          seen;
    lcd_timing_tracker  timing;

    lcd_mode_line_timing_top u_top
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .elapsed_ticks     (elapsed_ticks),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .lcd_mode          (lcd_mode),
        .line_number       (line_number),
        .vblank_irq        (vblank_irq),
        .line_render       (line_render),
        .frame_start       (frame_start),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .vblank_irq_enable (vblank_irq_enable)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Everything that crosses a handshake is observed at the rising edge, where
    // the values that were set up at the preceding falling edge are stable. An
    // accepted input advances the tracker at once; an accepted result is
    // compared with the oldest result still owed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                timing.note_ticks(elapsed_ticks);
            if (out_valid && !out_stall)
            begin
                seen.mode   = lcd_mode;
                seen.line   = line_number;
                seen.irq    = vblank_irq;
                seen.render = line_render;
                seen.frame  = frame_start;
                timing.check_result(seen);
            end
        end
    end

    // Result side. Normally the stall is drawn at random per cycle at the rate
    // the main process sets. Once asked, it holds the stall high for a long
    // stretch counted here, so the block's two registers fill and it must stall
    // the sender, who keeps offering items the whole time.
    initial
    begin : result_sink
        int hold_left;
        hold_left      = 0;
        out_stall      = 1'b0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && long_hold_req && !long_hold_done)
            begin
                hold_left      = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Hang detection: counts rising edges at which nothing at all was accepted.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one tick count, after a random number of idle cycles, and returns at
    // the falling edge after it was taken. The valid stays high into the next
    // call when no idle cycle is drawn, so back-to-back items are possible.
    task automatic send_ticks(input logic [TICKS_W-1:0] ticks);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        elapsed_ticks <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits for every owed result, then lets the pipeline settle.
    task automatic wait_drained();
        while (timing.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register writes only happen with nothing in flight, so the tracker can
    // take the new value at the same edge as the block.
    task automatic write_irq_enable(input logic en);
        cfg_valid         <= 1'b1;
        vblank_irq_enable <= en;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        timing.set_irq_enable(en);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase of a fixed number of items. Tick counts lean toward the
    // high end so the machine moves through many modes and lines; the rest are
    // drawn over the full range.
    task automatic run_phase(input int tx_pct, input int rx_pct, input logic irq_en,
                             input logic with_hold);
        int                 count;
        logic [TICKS_W-1:0] ticks;
        wait_drained();
        write_irq_enable(irq_en);
        tx_idle_pct  = tx_pct;
        rx_idle_pct <= rx_pct;
        count        = 0;
        while (count < PHASE_ITEMS)
        begin
            if (with_hold && count == 40)
                long_hold_req <= 1'b1;
            if ($urandom_range(99) < 85)
                ticks = $urandom_range(63, 40);
            else
                ticks = $urandom_range(63, 0);
            send_ticks(ticks);
            count++;
        end
        in_valid <= 1'b0;
    endtask

    // Directed opening: from reset, the extremes of the tick field, each single
    // bit on its own, exact hits on the OAM, transfer and HBLANK lengths with
    // no leftover, and transitions that carry leftover ticks into the next mode.
    logic [TICKS_W-1:0] opening_ticks[22] = '{
        6'd0,  6'd63, 6'd17, 6'd0,  6'd63, 6'd63, 6'd46, 6'd63, 6'd63, 6'd63, 6'd15,
        6'd63, 6'd63, 6'd1,  6'd2,  6'd4,  6'd8,  6'd16, 6'd32, 6'd62, 6'd0,  6'd63
    };

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        elapsed_ticks     = '0;
        cfg_valid         = 1'b0;
        vblank_irq_enable = 1'b0;
        long_hold_req     = 1'b0;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        timing            = new();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items run with the enable written to its low extreme.
        write_irq_enable(1'b0);
        tx_idle_pct  = 31;
        rx_idle_pct <= 50;
        foreach (opening_ticks[i])
            send_ticks(opening_ticks[i]);
        in_valid <= 1'b0;

        // Three random phases: sender idles less than receiver, then the reverse,
        // then neither idles, with the long receiver hold-off in the last one.
        // The interrupt enable toggles between phases.
        run_phase(31, 50, 1'b1, 1'b0);
        run_phase(50, 31, 1'b0, 1'b0);
        run_phase(0, 0, 1'b1, 1'b1);

        wait_drained();
        if (timing.pending() != 0)
            timing.report("results never produced, count", timing.pending(), 0);

        $display("Covered %0d tick items and %0d results across three idle mixes.",
                 timing.items_taken, timing.results_seen);
        $display("Saw %0d VBLANK entries, %0d interrupts, %0d line renders, %0d frame wraps.",
                 timing.vblank_entries, timing.irq_count, timing.render_count,
                 timing.frame_count);
        if (timing.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
